// ===== hdl/sit_pkg.sv =====
`timescale 1ns / 1ps
// Package for the segment intersection test core: widths, item types and the
// record handed from one divider cell to the next. No dependencies.
package sit_pkg;

    localparam int COORD_W = 32;                 // coordinate width, signed Q16.16
    localparam int DIFF_W  = COORD_W + 1;        // endpoint differences
    localparam int PROD_W  = 2 * DIFF_W;         // one cross-product term
    localparam int CROSS_W = PROD_W + 1;         // den, na, nb
    localparam int NUM_W   = CROSS_W + DIFF_W;   // na * dax, na * day
    localparam int QUO_W   = COORD_W + 1;        // quotient bits kept before overflow
    localparam int SUM_W   = COORD_W + 3;        // signed rounded quotient and sum
    localparam int LO_W    = (CROSS_W + 1) / 2;  // low slice of na for the split multiply
    localparam int HI_W    = CROSS_W - LO_W;     // high slice of na

    // Input item: two segments
    typedef struct packed {
        logic signed [COORD_W-1:0] a_start_x;
        logic signed [COORD_W-1:0] a_start_y;
        logic signed [COORD_W-1:0] a_end_x;
        logic signed [COORD_W-1:0] a_end_y;
        logic signed [COORD_W-1:0] b_start_x;
        logic signed [COORD_W-1:0] b_start_y;
        logic signed [COORD_W-1:0] b_end_x;
        logic signed [COORD_W-1:0] b_end_y;
    } seg_pair_t;

    // Result item
    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
        logic                      parallel;
    } cross_result_t;

    // Record moving down the divider chain (both x and y lanes)
    typedef struct packed {
        logic                      valid;
        logic [CROSS_W-1:0]        dmag;   // |den|
        logic [NUM_W-1:0]          rx;     // partial remainder, x lane
        logic [NUM_W-1:0]          ry;     // partial remainder, y lane
        logic [QUO_W-1:0]          qx;
        logic [QUO_W-1:0]          qy;
        logic                      negx;   // quotient sign, x lane
        logic                      negy;
        logic                      ovx;    // quotient too large: saturate
        logic                      ovy;
        logic signed [COORD_W-1:0] basex;  // start point of segment A
        logic signed [COORD_W-1:0] basey;
        logic                      hit;
        logic                      par;
    } div_cell_t;

endpackage

// ===== hdl/sit_front.sv =====
`timescale 1ns / 1ps
// Front pipeline: differences, cross products, hit test, split numerator
// multiply, magnitudes and overflow check. Uses sit_pkg.
module sit_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               seg_valid,
    input  sit_pkg::seg_pair_t seg,
    output sit_pkg::div_cell_t head
);

    localparam int CW = sit_pkg::COORD_W;
    localparam int DW = sit_pkg::DIFF_W;
    localparam int PW = sit_pkg::PROD_W;
    localparam int XW = sit_pkg::CROSS_W;
    localparam int NW = sit_pkg::NUM_W;
    localparam int QW = sit_pkg::QUO_W;
    localparam int LW = sit_pkg::LO_W;
    localparam int HW = sit_pkg::HI_W;

    logic [6:0] v_reg;

    // stage 1: differences
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg, ex_reg, ey_reg;
    logic signed [CW-1:0] bx1_reg, by1_reg;
    // stage 2: products
    logic signed [PW-1:0] p_ydx_reg, p_xdy_reg, p_xey_reg, p_yex_reg, p_dxey_reg, p_dyex_reg;
    logic signed [DW-1:0] dax2_reg, day2_reg;
    logic signed [CW-1:0] bx2_reg, by2_reg;
    // stage 3: den, na, nb
    logic signed [XW-1:0] den3_reg, na3_reg, nb3_reg;
    logic signed [DW-1:0] dax3_reg, day3_reg;
    logic signed [CW-1:0] bx3_reg, by3_reg;
    // stage 4: partial products, hit
    logic signed [LW+DW:0]   mxlo_reg, mylo_reg;
    logic signed [HW+DW-1:0] mxhi_reg, myhi_reg;
    logic signed [XW-1:0]    den4_reg;
    logic                    hit4_reg, par4_reg;
    logic signed [CW-1:0]    bx4_reg, by4_reg;
    // stage 5: full numerators
    logic signed [NW-1:0] nx5_reg, ny5_reg;
    logic signed [XW-1:0] den5_reg;
    logic                 hit5_reg, par5_reg;
    logic signed [CW-1:0] bx5_reg, by5_reg;
    // stage 6 and 7: magnitudes, then overflow flags
    sit_pkg::div_cell_t s6_reg, s7_reg, s7_next;

    // stage 3 hit test on sign-normalized values
    logic                 neg3;
    logic signed [XW-1:0] dn3, an3, bn3;
    logic                 hit3;
    logic [HW-1:0]        na_hi, ny_hi;

    assign neg3  = den3_reg[XW-1];
    assign dn3   = neg3 ? -den3_reg : den3_reg;
    assign an3   = neg3 ? -na3_reg  : na3_reg;
    assign bn3   = neg3 ? -nb3_reg  : nb3_reg;
    assign hit3  = (den3_reg != '0) && !an3[XW-1] && (an3 <= dn3)
                   && !bn3[XW-1] && (bn3 <= dn3);
    assign na_hi = na3_reg[XW-1:LW];
    assign ny_hi = na3_reg[XW-1:LW];

    // quotient needs more than QW bits: result saturates
    always_comb
    begin
        s7_next     = s6_reg;
        s7_next.ovx = s6_reg.rx >= {s6_reg.dmag, {QW{1'b0}}};
        s7_next.ovy = s6_reg.ry >= {s6_reg.dmag, {QW{1'b0}}};
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[5:0], seg_valid};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dax_reg <= $signed({seg.a_end_x[CW-1], seg.a_end_x})
                       - $signed({seg.a_start_x[CW-1], seg.a_start_x});
            day_reg <= $signed({seg.a_end_y[CW-1], seg.a_end_y})
                       - $signed({seg.a_start_y[CW-1], seg.a_start_y});
            dbx_reg <= $signed({seg.b_end_x[CW-1], seg.b_end_x})
                       - $signed({seg.b_start_x[CW-1], seg.b_start_x});
            dby_reg <= $signed({seg.b_end_y[CW-1], seg.b_end_y})
                       - $signed({seg.b_start_y[CW-1], seg.b_start_y});
            ex_reg  <= $signed({seg.a_start_x[CW-1], seg.a_start_x})
                       - $signed({seg.b_start_x[CW-1], seg.b_start_x});
            ey_reg  <= $signed({seg.a_start_y[CW-1], seg.a_start_y})
                       - $signed({seg.b_start_y[CW-1], seg.b_start_y});
            bx1_reg <= seg.a_start_x;
            by1_reg <= seg.a_start_y;

            p_ydx_reg  <= dby_reg * dax_reg;
            p_xdy_reg  <= dbx_reg * day_reg;
            p_xey_reg  <= dbx_reg * ey_reg;
            p_yex_reg  <= dby_reg * ex_reg;
            p_dxey_reg <= dax_reg * ey_reg;
            p_dyex_reg <= day_reg * ex_reg;
            dax2_reg   <= dax_reg;
            day2_reg   <= day_reg;
            bx2_reg    <= bx1_reg;
            by2_reg    <= by1_reg;

            den3_reg <= XW'(p_ydx_reg) - XW'(p_xdy_reg);
            na3_reg  <= XW'(p_xey_reg) - XW'(p_yex_reg);
            nb3_reg  <= XW'(p_dxey_reg) - XW'(p_dyex_reg);
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;

            mxlo_reg <= $signed({1'b0, na3_reg[LW-1:0]}) * dax3_reg;
            mylo_reg <= $signed({1'b0, na3_reg[LW-1:0]}) * day3_reg;
            mxhi_reg <= $signed(na_hi) * dax3_reg;
            myhi_reg <= $signed(ny_hi) * day3_reg;
            den4_reg <= den3_reg;
            hit4_reg <= hit3;
            par4_reg <= (den3_reg == '0);
            bx4_reg  <= bx3_reg;
            by4_reg  <= by3_reg;

            nx5_reg  <= (NW'(mxhi_reg) <<< LW) + NW'(mxlo_reg);
            ny5_reg  <= (NW'(myhi_reg) <<< LW) + NW'(mylo_reg);
            den5_reg <= den4_reg;
            hit5_reg <= hit4_reg;
            par5_reg <= par4_reg;
            bx5_reg  <= bx4_reg;
            by5_reg  <= by4_reg;

            s6_reg.valid <= 1'b0;
            s6_reg.dmag  <= den5_reg[XW-1] ? XW'(-den5_reg) : XW'(den5_reg);
            s6_reg.rx    <= nx5_reg[NW-1] ? NW'(-nx5_reg) : NW'(nx5_reg);
            s6_reg.ry    <= ny5_reg[NW-1] ? NW'(-ny5_reg) : NW'(ny5_reg);
            s6_reg.qx    <= '0;
            s6_reg.qy    <= '0;
            s6_reg.negx  <= nx5_reg[NW-1] ^ den5_reg[XW-1];
            s6_reg.negy  <= ny5_reg[NW-1] ^ den5_reg[XW-1];
            s6_reg.ovx   <= 1'b0;
            s6_reg.ovy   <= 1'b0;
            s6_reg.basex <= bx5_reg;
            s6_reg.basey <= by5_reg;
            s6_reg.hit   <= hit5_reg;
            s6_reg.par   <= par5_reg;

            s7_reg <= s7_next;
        end
    end

    always_comb
    begin
        head       = s7_reg;
        head.valid = v_reg[6];
    end

endmodule

// ===== hdl/sit_cell.sv =====
`timescale 1ns / 1ps
// One restoring-divide cell: settles quotient bit BIT of both lanes and hands
// the record to the next cell. Uses sit_pkg.
module sit_cell
#(
    parameter int BIT = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  sit_pkg::div_cell_t prev,
    output sit_pkg::div_cell_t next
);

    localparam int NW = sit_pkg::NUM_W;

    logic [NW-1:0]      dsh;
    logic               tx, ty;
    sit_pkg::div_cell_t cell_next, cell_reg;
    logic               valid_reg;

    // trial subtract of the shifted divisor
    assign dsh = NW'(prev.dmag) << BIT;
    assign tx  = prev.rx >= dsh;
    assign ty  = prev.ry >= dsh;

    always_comb
    begin
        cell_next = prev;
        if (tx)
        begin
            cell_next.rx      = prev.rx - dsh;
            cell_next.qx[BIT] = 1'b1;
        end
        if (ty)
        begin
            cell_next.ry      = prev.ry - dsh;
            cell_next.qy[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    always_comb
    begin
        next       = cell_reg;
        next.valid = valid_reg;
    end

endmodule

// ===== hdl/sit_back.sv =====
`timescale 1ns / 1ps
// Back end: rounding, sign, add of the start point, saturation and the
// output register. Uses sit_pkg.
module sit_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  sit_pkg::div_cell_t     tail,
    output logic                   res_valid,
    output sit_pkg::cross_result_t res
);

    localparam int CW = sit_pkg::COORD_W;
    localparam int XW = sit_pkg::CROSS_W;
    localparam int QW = sit_pkg::QUO_W;
    localparam int SW = sit_pkg::SUM_W;

    logic                  rndx, rndy;
    logic [QW:0]           qrx, qry;
    logic signed [SW-1:0]  qsx_reg, qsy_reg;
    logic                  ovx_reg, ovy_reg, negx_reg, negy_reg, hit_reg, par_reg;
    logic signed [CW-1:0]  bx_reg, by_reg;
    logic                  v1_reg, v2_reg;
    logic signed [SW-1:0]  sx, sy;
    sit_pkg::cross_result_t res_next, res_reg;

    // round half away from zero: remainder below |den| here
    assign rndx = {tail.rx[XW-1:0], 1'b0} >= {1'b0, tail.dmag};
    assign rndy = {tail.ry[XW-1:0], 1'b0} >= {1'b0, tail.dmag};
    assign qrx  = {1'b0, tail.qx} + (QW+1)'(rndx);
    assign qry  = {1'b0, tail.qy} + (QW+1)'(rndy);

    assign sx = SW'(bx_reg) + qsx_reg;
    assign sy = SW'(by_reg) + qsy_reg;

    function automatic logic signed [CW-1:0] clamp(input logic ov, input logic neg,
                                                   input logic signed [SW-1:0] s);
        logic signed [SW-1:0] hi, lo;
        hi = SW'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - SW'(1);
        if (ov)
        begin
            clamp = neg ? lo[CW-1:0] : hi[CW-1:0];
        end
        else if (s > hi)
        begin
            clamp = hi[CW-1:0];
        end
        else if (s < lo)
        begin
            clamp = lo[CW-1:0];
        end
        else
        begin
            clamp = s[CW-1:0];
        end
    endfunction

    // final result, parallel case forced to zero
    always_comb
    begin
        res_next.parallel = par_reg;
        res_next.hit      = hit_reg && !par_reg;
        res_next.cross_x  = par_reg ? '0 : clamp(ovx_reg, negx_reg, sx);
        res_next.cross_y  = par_reg ? '0 : clamp(ovy_reg, negy_reg, sy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= tail.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qsx_reg  <= tail.negx ? -SW'(qrx) : SW'(qrx);
            qsy_reg  <= tail.negy ? -SW'(qry) : SW'(qry);
            ovx_reg  <= tail.ovx;
            ovy_reg  <= tail.ovy;
            negx_reg <= tail.negx;
            negy_reg <= tail.negy;
            hit_reg  <= tail.hit;
            par_reg  <= tail.par;
            bx_reg   <= tail.basex;
            by_reg   <= tail.basey;
            res_reg  <= res_next;
        end
    end

    assign res_valid = v2_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/segment_intersection_test_core.sv =====
`timescale 1ns / 1ps
// Segment crossing test. One item (two segments, signed Q16.16) is taken every
// cycle and passes through 7 front stages for the cross products and split
// numerator multiply, 33 divider cells that each settle one quotient bit for x
// and y, and 2 stages for rounding and saturation. The whole pipeline holds
// while a result waits on res_stall. Parallel or degenerate segments give
// parallel = 1, hit = 0 and a zero crossing point.
module segment_intersection_test_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   seg_valid,
    output logic                   seg_stall,
    input  sit_pkg::seg_pair_t     seg,
    output logic                   res_valid,
    input  logic                   res_stall,
    output sit_pkg::cross_result_t res
);

    localparam int QW = sit_pkg::QUO_W;

    logic               advance;
    sit_pkg::div_cell_t chain [QW+1];

    // pipeline moves unless a finished item is held at the output
    assign advance   = !(res_valid && res_stall);
    assign seg_stall = !advance;

    sit_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .seg_valid (seg_valid),
        .seg       (seg),
        .head      (chain[0])
    );

    // divider cells, most significant quotient bit first
    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        sit_cell #(.BIT(QW - 1 - k)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .prev    (chain[k]),
            .next    (chain[k+1])
        );
    end

    sit_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tail      (chain[QW]),
        .res_valid (res_valid),
        .res       (res)
    );

    // parallel result carries no hit and no point
    a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.parallel |-> !res.hit && res.cross_x == '0 && res.cross_y == '0)
        else $error("parallel item with nonzero fields");

    // input side is held only by a held output item
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        seg_stall |-> res_valid && res_stall)
        else $error("input stalled without output back-pressure");

    // a held output item stays in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("held item changed");

endmodule
